### sv/md5_pkg.sv
`default_nettype none

package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LAST_POS = 6'd63;
  localparam logic [5:0]  LEN_POS = 6'd55;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [1:0]  LAST_WORD = 2'd3;
  localparam logic [3:0]  LEN_LO_WORD = 4'd14;
  localparam logic [3:0]  LEN_HI_WORD = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } st_t;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_shift(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

endpackage

`default_nettype wire

### sv/md5_message_digest_top.sv
// Byte transaction: accepted in idle; a byte that fills a block starts the 64 rounds and the
// chaining add, during which no input is accepted.
// Closing transaction: padding bytes up to offset 55, length write, 64 rounds and chaining
// add per block (two blocks when the tail reaches offset 56), then four output transactions.
// The single round unit (one MD5 step per cycle) computes every block.
// Reset (rst_n low, synchronous): chaining values to the MD5 IV, counters and state cleared.
`default_nettype none

module md5_message_digest_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] has_byte
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [1:0]       out_tuser,  // [1:0] word_index
  output logic             out_tlast   // final_word
);
  import md5_pkg::*;

  st_t         state_r, state_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] rnd_r [4];
  logic [31:0] rnd_nxt [4];
  logic [31:0] words_r [16];
  logic [31:0] words_nxt [16];
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  rc_r, rc_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        pad_r, pad_nxt;
  logic        first_r, first_nxt;
  logic        fin_r, fin_nxt;

  logic        in_acc, out_acc;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [31:0] f_val, msg, sum, new_b;
  logic [3:0]  g_idx;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser && pos_r == LAST_POS) begin
            state_nxt = ST_COMP;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pos_r == LEN_POS) begin
          state_nxt = ST_LEN;
        end else if (pos_r == LAST_POS) begin
          state_nxt = ST_COMP;
        end
      end
      ST_LEN: state_nxt = ST_COMP;
      ST_COMP: begin
        if (rc_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (fin_r) begin
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_tready && idx_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    out_tdata  = chain_r[idx_r];
    out_tuser  = idx_r;
    out_tlast  = (idx_r == LAST_WORD);
  end

  // round unit
  always_comb begin
    case (rc_r[5:4])
      2'd0: begin
        f_val = (rnd_r[1] & rnd_r[2]) | (~rnd_r[1] & rnd_r[3]);
        g_idx = rc_r[3:0];
      end
      2'd1: begin
        f_val = (rnd_r[3] & rnd_r[1]) | (~rnd_r[3] & rnd_r[2]);
        g_idx = 4'((rc_r[3:0] << 2) + rc_r[3:0] + 4'd1);
      end
      2'd2: begin
        f_val = rnd_r[1] ^ rnd_r[2] ^ rnd_r[3];
        g_idx = 4'((rc_r[3:0] << 1) + rc_r[3:0] + 4'd5);
      end
      default: begin
        f_val = rnd_r[2] ^ (rnd_r[1] | ~rnd_r[3]);
        g_idx = 4'((rc_r[3:0] << 3) - rc_r[3:0]);
      end
    endcase
    msg   = words_r[g_idx];
    sum   = rnd_r[0] + f_val + round_const(rc_r) + msg;
    new_b = rnd_r[1] + rotl(sum, round_shift({rc_r[5:4], rc_r[1:0]}));
  end

  always_comb begin
    chain_nxt = chain_r;
    rnd_nxt   = rnd_r;
    words_nxt = words_r;
    pos_nxt   = pos_r;
    bits_nxt  = bits_r;
    rc_nxt    = rc_r;
    idx_nxt   = idx_r;
    pad_nxt   = pad_r;
    first_nxt = first_r;
    fin_nxt   = fin_r;
    wr_en     = 1'b0;
    wr_byte   = in_tdata;

    if (in_acc) begin
      if (in_tuser) begin
        wr_en    = 1'b1;
        bits_nxt = bits_r + 64'd8;
        pos_nxt  = pos_r + 6'd1;
      end
      if (in_tlast) begin
        pad_nxt   = 1'b1;
        first_nxt = 1'b1;
      end
    end

    if (state_r == ST_PAD) begin
      wr_en     = 1'b1;
      wr_byte   = first_r ? PAD_BYTE : 8'h00;
      first_nxt = 1'b0;
      pos_nxt   = pos_r + 6'd1;
    end

    if (wr_en) begin
      words_nxt[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] = wr_byte;
    end

    if (state_r == ST_LEN) begin
      words_nxt[LEN_LO_WORD] = bits_r[31:0];
      words_nxt[LEN_HI_WORD] = bits_r[63:32];
      fin_nxt = 1'b1;
    end

    if (state_nxt == ST_COMP && state_r != ST_COMP) begin
      rnd_nxt = chain_r;
    end

    if (state_r == ST_COMP) begin
      rnd_nxt[0] = rnd_r[3];
      rnd_nxt[1] = new_b;
      rnd_nxt[2] = rnd_r[1];
      rnd_nxt[3] = rnd_r[2];
      rc_nxt     = rc_r + 6'd1;
    end

    if (state_r == ST_ADD) begin
      for (int i = 0; i < 4; i++) begin
        chain_nxt[i] = chain_r[i] + rnd_r[i];
      end
    end

    if (out_acc) begin
      idx_nxt = idx_r + 2'd1;
      if (idx_r == LAST_WORD) begin
        chain_nxt = '{IV_A, IV_B, IV_C, IV_D};
        pos_nxt   = '0;
        bits_nxt  = '0;
        pad_nxt   = 1'b0;
        fin_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chain_r <= '{IV_A, IV_B, IV_C, IV_D};
      rnd_r   <= '{default: 32'h0};
      pos_r   <= '0;
      bits_r  <= '0;
      rc_r    <= '0;
      idx_r   <= '0;
      pad_r   <= 1'b0;
      first_r <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      rnd_r   <= rnd_nxt;
      pos_r   <= pos_nxt;
      bits_r  <= bits_nxt;
      rc_r    <= rc_nxt;
      idx_r   <= idx_nxt;
      pad_r   <= pad_nxt;
      first_r <= first_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r <= words_nxt;
  end

endmodule

`default_nettype wire

### sv/md5_chk.sv
`default_nettype none

module md5_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        in_tuser,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled output transaction changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == 2'd3)
    else $error("final word without index 3");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && !in_tready)
    else $error("digest burst broken");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted during finish");

endmodule

bind md5_message_digest_top md5_chk u_md5_chk (.*);

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RST_CYCLES     = 10;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int RAND_ITEMS     = 140;
  localparam int MAX_REPORTS    = 10;
  localparam int SETTLE_CYCLES  = 200;
  localparam int NOISE_PCT      = 10;

  localparam logic [0:63][31:0] SINE_K = {
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam logic [0:15][4:0] ROT_AMT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // lengths that land the tail on either side of the length field and block end
  localparam logic [0:7][7:0] EDGE_LENS = {
    8'd55, 8'd56, 8'd57, 8'd63, 8'd64, 8'd65, 8'd119, 8'd120
  };

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        fin;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] has_byte
  logic        in_tlast;   // is_last
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] digest_word
  logic [1:0]  out_tuser;  // [1:0] word_index
  logic        out_tlast;  // final_word

  md5_message_digest_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // digest predictor state
  logic [31:0]  chain [4];
  logic [31:0]  msg_words [16];
  logic [5:0]   blk_pos;
  logic [63:0]  msg_bits;
  digest_beat_t digest_q[$];

  int  fail_cnt     = 0;
  int  cycle_cnt    = 0;
  int  sent_items   = 0;
  int  stall_left   = 0;
  bit  idle_on      = 1'b0;
  bit  stall_on     = 1'b0;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void md5_restart();
    chain[0] = IV_A;
    chain[1] = IV_B;
    chain[2] = IV_C;
    chain[3] = IV_D;
    blk_pos  = '0;
    msg_bits = '0;
  endfunction

  function automatic void put_msg_byte(input int p, input logic [7:0] b);
    msg_words[p / 4][(p % 4) * 8 +: 8] = b;
  endfunction

  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int r, g;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = 5 * r + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * r + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * r;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + SINE_K[r] + msg_words[g % 16],
                    32'(ROT_AMT[(r / 16) * 4 + r % 4]));
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  function automatic void md5_absorb(input logic [7:0] d, input logic has, input logic last);
    int p;
    int i;
    digest_beat_t beat;
    if (has) begin
      put_msg_byte(int'(blk_pos), d);
      msg_bits += 64'd8;
      blk_pos++;
      if (blk_pos == 0)
        md5_compress();
    end
    if (!last)
      return;
    p = int'(blk_pos);
    put_msg_byte(p, PAD_BYTE);
    p++;
    if (p > 56) begin
      while (p < 64) begin
        put_msg_byte(p, 8'h00);
        p++;
      end
      md5_compress();
      p = 0;
    end
    while (p < 56) begin
      put_msg_byte(p, 8'h00);
      p++;
    end
    msg_words[LEN_LO_WORD] = msg_bits[31:0];
    msg_words[LEN_HI_WORD] = msg_bits[63:32];
    md5_compress();
    for (i = 0; i < 4; i++) begin
      beat.word = chain[i];
      beat.idx  = 2'(i);
      beat.fin  = (beat.idx == LAST_WORD);
      digest_q.push_back(beat);
    end
    md5_restart();
  endfunction

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        note_fail($sformatf("unexpected digest transaction: word=%h idx=%0d last=%0b",
                            out_tdata, out_tuser, out_tlast));
      end else begin
        want = digest_q.pop_front();
        if (out_tdata !== want.word || out_tuser !== want.idx || out_tlast !== want.fin)
          note_fail($sformatf("digest mismatch: expected word=%h idx=%0d last=%0b, got word=%h idx=%0d last=%0b",
                              want.word, want.idx, want.fin, out_tdata, out_tuser, out_tlast));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > TIMEOUT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(input logic [7:0] d, input logic has, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 7)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = d;
    in_tuser  = has;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    md5_absorb(d, has, last);
    if (has || last)
      sent_items++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_message(input int len, input bit fuse_last);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < NOISE_PCT)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, fuse_last && (i == len - 1));
    end
    if (len == 0 || !fuse_last)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (digest_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic test_empty_message();
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_abc();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  task automatic test_byte_extremes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_pause_until_done();
    send_message($urandom_range(1, 12), 1'($urandom_range(0, 1)));
    wait_drained();
    send_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_messages();
    int sel;
    int len;
    sent_items  = 0;
    idle_on     = 1'b1;
    stall_on    = 1'b1;
    while (sent_items < RAND_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 75)
        len = $urandom_range(0, 20);
      else if (sel < 90)
        len = int'(EDGE_LENS[$urandom_range(0, 7)]);
      else
        len = $urandom_range(21, 130);
      send_message(len, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0)
        wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    send_message(56, 1'b1);
    send_message(0, 1'b0);
    send_message($urandom_range(1, 20), 1'b1);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    md5_restart();
    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_empty_message();
    test_abc();
    test_byte_extremes();
    test_pause_until_done();
    test_random_messages();
    test_back_to_back();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
